// ===== hw/rtl/pdpc_pkg.sv =====
`timescale 1ns / 1ps

package pdpc_pkg;

    // Table size default, overridable on the top level
    localparam int TABLE_DEPTH_DEF = 16;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int DELAY_W = 24;
    localparam int MS_W    = 14;

    // Item kinds
    localparam logic FUNC_RULE   = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    // Packet qualification constants
    localparam logic [31:0]        MARK_INPUT = 32'd1;
    localparam logic [3:0]         IP_V4      = 4'd4;
    localparam logic [7:0]         PROTO_ICMP = 8'd1;
    localparam logic [7:0]         PROTO_TCP  = 8'd6;
    localparam logic [15:0]        TCP_LEN_A  = 16'd60;
    localparam logic [15:0]        TCP_LEN_B  = 16'd52;
    localparam logic [LEN_W-1:0]   ADDR_BITS  = 6'd32;
    localparam logic [DELAY_W-1:0] US_PER_MS  = 24'd1000;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT = 2'd0,
        VERDICT_DELAY  = 2'd1,
        VERDICT_HOLD   = 2'd2
    } verdict_t;

    // Input beat
    typedef struct packed {
        logic               func;
        logic [31:0]        queue_id;
        logic [31:0]        pkt_mark;
        logic [3:0]         ip_ver;
        logic [7:0]         ip_protocol;
        logic [15:0]        packet_length;
        logic [ADDR_W-1:0]  dest_addr;
        logic [ADDR_W-1:0]  new_prefix;
        logic [LEN_W-1:0]   new_prefix_len;
        logic [DELAY_W-1:0] new_delay_us;
    } in_beat_t;

    // Output beat
    typedef struct packed {
        logic [31:0]        queue_id_out;
        verdict_t           verdict;
        logic [DELAY_W-1:0] delay_us;
        logic               rule_matched;
        logic               table_full;
    } out_beat_t;

    // One table entry
    typedef struct packed {
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   prefix_len;
        logic [DELAY_W-1:0] delay_us;
    } rule_t;

    // Compare result for the entry currently on the read port
    typedef struct packed {
        logic               hit;
        logic [DELAY_W-1:0] delay_us;
    } match_t;

    // Prefix test: length 0 covers everything, lengths above 32 act as 32
    function automatic logic prefix_covers(
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] prefix,
        input logic [LEN_W-1:0]  len
    );
        logic [LEN_W-1:0]  len_c;
        logic [ADDR_W-1:0] mask;
        len_c = (len > ADDR_BITS) ? ADDR_BITS : len;
        mask  = {ADDR_W{1'b1}} << (ADDR_BITS - len_c);
        return (len_c == '0) || (((addr ^ prefix) & mask) == '0);
    endfunction

endpackage

// ===== hw/rtl/packet_delay_prefix_classifier.sv =====
`timescale 1ns / 1ps

// First-match IPv4 prefix classifier. A rule beat (func 0) appends one entry to an ordered
// table of TABLE_DEPTH rules and returns a result with table_full set when the table was
// already full. A packet beat (func 1) with mark 1, version 4 and ICMP, or TCP of length 60
// or 52, is delayed by the first rule whose prefix covers dest_addr; the default delay
// (default_delay_ms * 1000 us) applies when no rule matches or the matching rule's delay is
// zero. Other protocols and a zero destination are held. Items are handled one at a time and
// in_stall is high while one is in flight. A rule beat or a packet that needs no lookup goes
// straight to ST_FINISH; a lookup passes through ST_SCAN, where the single compare unit walks
// the table one entry per cycle behind a registered memory read and stops at the first hit or
// at the last rule. The table needs no clearing after reset. default_delay_ms is written through
// cfg_write/cfg_data and should be changed only while the block is idle.
module packet_delay_prefix_classifier #(
    parameter int TABLE_DEPTH = pdpc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [pdpc_pkg::MS_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  pdpc_pkg::in_beat_t        in_beat,
    output logic                      out_valid,
    input  logic                      out_stall,
    output pdpc_pkg::out_beat_t       out_beat
);
    import pdpc_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [MS_W-1:0]      dflt_ms_reg, dflt_ms_next;
    logic                 out_valid_reg, out_valid_next;
    out_beat_t            out_beat_reg, out_beat_next;
    logic [31:0]          id_reg, id_next;
    logic [ADDR_W-1:0]    dst_reg, dst_next;
    verdict_t             verdict_reg, verdict_next;
    logic [DELAY_W-1:0]   rdelay_reg, rdelay_next;
    logic                 matched_reg, matched_next;
    logic                 full_reg, full_next;

    logic                 accept;
    logic                 tbl_wr_en;
    rule_t                tbl_wr_rule;
    match_t               tbl_match;
    logic [DELAY_W-1:0]   dflt_us;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Default delay in microseconds
    assign dflt_us = DELAY_W'(dflt_ms_reg) * US_PER_MS;

    // Rule append goes straight to the table on accept when the table has room
    assign tbl_wr_en = accept && (in_beat.func == FUNC_RULE) && (count_reg != DEPTH_C);
    always_comb
    begin
        tbl_wr_rule.prefix     = in_beat.new_prefix;
        tbl_wr_rule.prefix_len = in_beat.new_prefix_len;
        tbl_wr_rule.delay_us   = in_beat.new_delay_us;
    end

    pdpc_rule_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rule_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_rule (tbl_wr_rule),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .key     (dst_reg),
        .result  (tbl_match)
    );

    // Sequencer
    always_comb
    begin
        logic wants;
        wants          = 1'b0;
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = rd_pend_reg;
        dflt_ms_next   = dflt_ms_reg;
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        id_next        = id_reg;
        dst_next       = dst_reg;
        verdict_next   = verdict_reg;
        rdelay_next    = rdelay_reg;
        matched_next   = matched_reg;
        full_next      = full_reg;

        if (cfg_write)
        begin
            dflt_ms_next = cfg_data;
        end

        // Output beat taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    id_next       = in_beat.queue_id;
                    dst_next      = in_beat.dest_addr;
                    verdict_next  = VERDICT_ACCEPT;
                    rdelay_next   = '0;
                    matched_next  = 1'b0;
                    full_next     = 1'b0;
                    scan_idx_next = '0;
                    rd_pend_next  = 1'b0;
                    state_next    = ST_FINISH;
                    if (in_beat.func == FUNC_RULE)
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + ONE_C;
                        end
                    end
                    else if (in_beat.pkt_mark == MARK_INPUT && in_beat.ip_ver == IP_V4)
                    begin
                        if (in_beat.ip_protocol == PROTO_ICMP)
                        begin
                            wants = 1'b1;
                        end
                        else if (in_beat.ip_protocol == PROTO_TCP)
                        begin
                            wants = in_beat.packet_length inside {TCP_LEN_A, TCP_LEN_B};
                        end
                        else
                        begin
                            verdict_next = VERDICT_HOLD;
                        end

                        if (wants)
                        begin
                            if (in_beat.dest_addr == '0)
                            begin
                                verdict_next = VERDICT_HOLD;
                            end
                            else
                            begin
                                verdict_next = VERDICT_DELAY;
                                if (count_reg != '0)
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                    end
                end
            end

            // One entry read per cycle, compared in the next cycle
            ST_SCAN:
            begin
                if (rd_pend_reg && tbl_match.hit)
                begin
                    matched_next = 1'b1;
                    rdelay_next  = tbl_match.delay_us;
                    state_next   = ST_FINISH;
                end
                else if (scan_idx_reg == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + ONE_C;
                    rd_pend_next  = 1'b1;
                end
            end

            // Load the output register once it is free
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_beat_next.queue_id_out   = id_reg;
                    out_beat_next.verdict        = verdict_reg;
                    out_beat_next.rule_matched   = matched_reg;
                    out_beat_next.table_full     = full_reg;
                    if (verdict_reg == VERDICT_DELAY && rdelay_reg == '0)
                    begin
                        out_beat_next.delay_us = dflt_us;
                    end
                    else
                    begin
                        out_beat_next.delay_us = rdelay_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dflt_ms_reg   <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dflt_ms_reg   <= dflt_ms_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        out_beat_reg <= out_beat_next;
        id_reg       <= id_next;
        dst_reg      <= dst_next;
        verdict_reg  <= verdict_next;
        rdelay_reg   <= rdelay_next;
        matched_reg  <= matched_next;
        full_reg     <= full_next;
    end

`ifndef NO_ASSERTIONS
    // Table fill never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("rule count above table depth");

    // A dropped-rule result only when the table is full
    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_beat_reg.table_full) |-> (count_reg == DEPTH_C))
        else $error("table_full reported with room in the table");

    // A rule match always comes with a delay verdict
    a_match_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_beat_reg.rule_matched) |-> (out_beat_reg.verdict == VERDICT_DELAY))
        else $error("rule_matched without delay verdict");

    // An accepted rule with room grows the table by one
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_beat.func == FUNC_RULE && count_reg != DEPTH_C)
            |=> (count_reg == $past(count_reg) + ONE_C))
        else $error("rule append did not advance count");
`endif

endmodule

// ===== hw/rtl/pdpc_rule_table.sv =====
`timescale 1ns / 1ps

module pdpc_rule_table #(
    parameter int TABLE_DEPTH = pdpc_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  pdpc_pkg::rule_t          wr_rule,
    input  logic [IDX_W-1:0]         rd_addr,
    input  logic [pdpc_pkg::ADDR_W-1:0] key,
    output pdpc_pkg::match_t         result
);
    import pdpc_pkg::*;

    rule_t mem [TABLE_DEPTH];
    rule_t rd_rule_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rule;
        end
        rd_rule_reg <= mem[rd_addr];
    end

    // Prefix compare on the entry read last cycle
    always_comb
    begin
        result.hit      = prefix_covers(key, rd_rule_reg.prefix, rd_rule_reg.prefix_len);
        result.delay_us = rd_rule_reg.delay_us;
    end

endmodule

// ===== dv/packet_delay_prefix_classifier_tb.sv =====
`timescale 1ns / 1ps

module packet_delay_prefix_classifier_tb;

    import pdpc_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BEATS    = 103;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_write = 1'b0;
    logic [MS_W-1:0] cfg_data  = '0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    in_beat_t        in_beat   = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    out_beat_t       out_beat;

    // Mirror of the rule table and the default delay register
    logic [ADDR_W-1:0]  tbl_prefix [TABLE_DEPTH];
    logic [LEN_W-1:0]   tbl_len    [TABLE_DEPTH];
    logic [DELAY_W-1:0] tbl_delay  [TABLE_DEPTH];
    int                 tbl_count  = 0;
    logic [MS_W-1:0]    default_ms = '0;

    out_beat_t pending_verdicts [$];
    out_beat_t want_beat;
    int        fail_count   = 0;
    int        quiet_cycles = 0;
    int        stall_left   = 0;
    bit        idle_on      = 1'b1;

    packet_delay_prefix_classifier #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_beat  (in_beat),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_beat (out_beat)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Does a rule of this prefix and length cover addr
    function automatic logic covers(input logic [ADDR_W-1:0] addr,
                                    input logic [ADDR_W-1:0] pfx,
                                    input logic [LEN_W-1:0]  len);
        logic [LEN_W-1:0]  eff_len;
        logic [ADDR_W-1:0] mask;
        if (len == '0)
            return 1'b1;
        eff_len = (len > 6'd32) ? 6'd32 : len;
        mask    = 32'hFFFF_FFFF << (6'd32 - eff_len);
        return ((addr ^ pfx) & mask) == '0;
    endfunction

    // Expected verdict for one beat; rule beats update the table mirror
    function automatic out_beat_t classify(input in_beat_t b);
        out_beat_t          r;
        logic               qualifies;
        logic [DELAY_W-1:0] hit_delay;
        r.queue_id_out  = b.queue_id;
        r.verdict       = VERDICT_ACCEPT;
        r.delay_us      = '0;
        r.rule_matched  = 1'b0;
        r.table_full    = 1'b0;
        qualifies       = 1'b0;
        hit_delay       = '0;
        if (b.func == FUNC_RULE)
        begin
            if (tbl_count >= TABLE_DEPTH)
                r.table_full = 1'b1;
            else
            begin
                tbl_prefix[tbl_count] = b.new_prefix;
                tbl_len[tbl_count]    = b.new_prefix_len;
                tbl_delay[tbl_count]  = b.new_delay_us;
                tbl_count++;
            end
        end
        else if (b.pkt_mark == MARK_INPUT && b.ip_ver == IP_V4)
        begin
            if (b.ip_protocol == PROTO_ICMP)
                qualifies = 1'b1;
            else if (b.ip_protocol == PROTO_TCP)
                qualifies = (b.packet_length == TCP_LEN_A) || (b.packet_length == TCP_LEN_B);
            else
                r.verdict = VERDICT_HOLD;
            if (qualifies)
            begin
                if (b.dest_addr == '0)
                    r.verdict = VERDICT_HOLD;
                else
                begin
                    // first matching rule wins
                    for (int i = 0; i < tbl_count; i++)
                    begin
                        if (!r.rule_matched && covers(b.dest_addr, tbl_prefix[i], tbl_len[i]))
                        begin
                            r.rule_matched = 1'b1;
                            hit_delay      = tbl_delay[i];
                        end
                    end
                    r.verdict  = VERDICT_DELAY;
                    r.delay_us = (hit_delay != '0) ? hit_delay
                                                   : DELAY_W'(default_ms) * US_PER_MS;
                end
            end
        end
        return r;
    endfunction

    // Beat with every field random
    function automatic in_beat_t rand_beat();
        in_beat_t b;
        b.func           = 1'($urandom());
        b.queue_id       = $urandom();
        b.pkt_mark       = $urandom();
        b.ip_ver         = 4'($urandom());
        b.ip_protocol    = 8'($urandom());
        b.packet_length  = 16'($urandom());
        b.dest_addr      = $urandom();
        b.new_prefix     = $urandom();
        b.new_prefix_len = 6'($urandom());
        b.new_delay_us   = 24'($urandom());
        return b;
    endfunction

    function automatic in_beat_t pkt(input logic [31:0] mark, input logic [3:0] ver,
                                     input logic [7:0] proto, input logic [15:0] len,
                                     input logic [ADDR_W-1:0] dst);
        in_beat_t b;
        b               = rand_beat();
        b.func          = FUNC_PACKET;
        b.pkt_mark      = mark;
        b.ip_ver        = ver;
        b.ip_protocol   = proto;
        b.packet_length = len;
        b.dest_addr     = dst;
        return b;
    endfunction

    function automatic in_beat_t rule_beat(input logic [ADDR_W-1:0] pfx,
                                           input logic [LEN_W-1:0] len,
                                           input logic [DELAY_W-1:0] dly);
        in_beat_t b;
        b                = rand_beat();
        b.func           = FUNC_RULE;
        b.new_prefix     = pfx;
        b.new_prefix_len = len;
        b.new_delay_us   = dly;
        return b;
    endfunction

    // Offer one beat, hold it until accepted, then queue its verdict
    task automatic send_beat(input in_beat_t b);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do
            @(posedge clk);
        while (in_stall);
        pending_verdicts.push_back(classify(b));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_default_delay(input logic [MS_W-1:0] ms);
        quiesce();
        cfg_write <= 1'b1;
        cfg_data  <= ms;
        @(posedge clk);
        cfg_write  <= 1'b0;
        default_ms  = ms;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Qualification and hold cases against an empty table
    task automatic test_empty_table();
        in_beat_t b;
        idle_on = 1'b1;
        // zero default still gives a delay verdict
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_ICMP, 16'd84, 32'h0A00_0001));
        set_default_delay(14'h3FFF);
        b = pkt(MARK_INPUT, IP_V4, PROTO_ICMP, 16'd0, 32'hFFFF_FFFF);
        b.queue_id = 32'hFFFF_FFFF;
        send_beat(b);
        b = pkt(MARK_INPUT, IP_V4, PROTO_TCP, TCP_LEN_A, 32'h0102_0304);
        b.queue_id = 32'h0;
        send_beat(b);
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_TCP, TCP_LEN_B, 32'h0102_0305));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_TCP, 16'hFFFF, 32'h0102_0306));
        send_beat(pkt(MARK_INPUT, IP_V4, 8'd17, TCP_LEN_A, 32'h0102_0307));
        send_beat(pkt(MARK_INPUT, IP_V4, 8'hFF, 16'd0, 32'h0));
        // zero destination holds
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_ICMP, 16'd84, 32'h0));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_TCP, TCP_LEN_B, 32'h0));
        // wrong mark or version accepts now
        send_beat(pkt(32'h0, IP_V4, PROTO_ICMP, 16'd84, 32'h0A00_0001));
        send_beat(pkt(32'hFFFF_FFFF, IP_V4, PROTO_ICMP, 16'd84, 32'h0A00_0001));
        send_beat(pkt(MARK_INPUT, 4'd6, PROTO_ICMP, 16'd84, 32'h0A00_0001));
        send_beat(pkt(MARK_INPUT, 4'hF, PROTO_TCP, TCP_LEN_A, 32'h0A00_0001));
    endtask

    // First-match order, zero rule delay, over-long prefix length
    task automatic test_rule_lookup();
        set_default_delay(14'd5);
        send_beat(rule_beat(32'hC0A8_0101, 6'd40, 24'd777));
        send_beat(rule_beat(32'h0A00_0000, 6'd8, 24'd0));
        send_beat(rule_beat(32'hFFFF_FFFF, 6'd32, 24'hFF_FFFF));
        send_beat(rule_beat(32'h0A0B_0000, 6'd16, 24'd123));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_ICMP, 16'd84, 32'hC0A8_0101));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_ICMP, 16'd84, 32'hC0A8_0102));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_TCP, TCP_LEN_A, 32'h0A0B_0C0D));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_ICMP, 16'd84, 32'hFFFF_FFFF));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_TCP, TCP_LEN_B, 32'h0A0B_0001));
        send_beat(pkt(MARK_INPUT, IP_V4, PROTO_ICMP, 16'd84, 32'h0B00_0001));
        send_beat(pkt(MARK_INPUT, IP_V4, 8'd17, 16'd84, 32'h0A00_0001));
    endtask

    // Mostly well-formed packets aimed at stored prefixes; the table fills on the way
    task automatic test_random_traffic();
        in_beat_t        b;
        int              roll;
        logic [MS_W-1:0] ms;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            ms = (phase == 0) ? 14'd0 : (phase == 1) ? 14'h3FFF : 14'($urandom_range(0, 16383));
            set_default_delay(ms);
            idle_on = (phase % 3) != 2;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                b    = rand_beat();
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    // rule; a catch-all lands near the end of the table
                    b.func = FUNC_RULE;
                    roll   = $urandom_range(0, 99);
                    if (tbl_count == TABLE_DEPTH - 2)
                        b.new_prefix_len = '0;
                    else if (roll < 70)
                        b.new_prefix_len = 6'($urandom_range(8, 32));
                    else if (roll < 85)
                        b.new_prefix_len = 6'($urandom_range(33, 63));
                    else
                        b.new_prefix_len = 6'($urandom_range(1, 7));
                    if ($urandom_range(0, 4) == 0)
                        b.new_delay_us = '0;
                end
                else if (roll < 8)
                    b.func = FUNC_PACKET;
                else if (roll < 14)
                begin
                    // near miss on one qualifier
                    b.func       = FUNC_PACKET;
                    b.pkt_mark   = MARK_INPUT;
                    b.ip_ver     = IP_V4;
                    case ($urandom_range(0, 3))
                        0: b.pkt_mark = 32'($urandom_range(0, 3));
                        1: b.ip_ver = 4'($urandom());
                        2:
                        begin
                            b.ip_protocol = PROTO_TCP;
                            if ($urandom_range(0, 1))
                                b.packet_length = TCP_LEN_A + 16'($urandom_range(0, 2)) - 16'd1;
                            else
                                b.packet_length = TCP_LEN_B + 16'($urandom_range(0, 2)) - 16'd1;
                        end
                        default: b.ip_protocol = 8'($urandom());
                    endcase
                end
                else
                begin
                    b.func       = FUNC_PACKET;
                    b.pkt_mark   = MARK_INPUT;
                    b.ip_ver     = IP_V4;
                    if ($urandom_range(0, 1))
                        b.ip_protocol = PROTO_ICMP;
                    else
                    begin
                        b.ip_protocol   = PROTO_TCP;
                        b.packet_length = $urandom_range(0, 1) ? TCP_LEN_A : TCP_LEN_B;
                    end
                    roll = $urandom_range(0, 99);
                    if (roll < 5)
                        b.dest_addr = '0;
                    else if (roll < 85 && tbl_count > 0)
                        b.dest_addr = tbl_prefix[$urandom_range(0, tbl_count - 1)]
                                      ^ ($urandom() >> $urandom_range(0, 31));
                end
                send_beat(b);
            end
        end
    endtask

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (stall_left == 0)
            stall_left = idle_len();
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left  = stall_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected none, actual id %h",
                         $time, out_beat.queue_id_out);
                fail_count++;
            end
            else
            begin
                want_beat = pending_verdicts.pop_front();
                compare_field("queue_id_out", want_beat.queue_id_out, out_beat.queue_id_out);
                compare_field("verdict", 32'(want_beat.verdict), 32'(out_beat.verdict));
                compare_field("delay_us", 32'(want_beat.delay_us), 32'(out_beat.delay_us));
                compare_field("rule_matched", 32'(want_beat.rule_matched),
                              32'(out_beat.rule_matched));
                compare_field("table_full", 32'(want_beat.table_full),
                              32'(out_beat.table_full));
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("packet_delay_prefix_classifier_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_rule_lookup();
        test_random_traffic();
        quiesce();
        repeat (TABLE_DEPTH + 4) @(posedge clk);
        if (fail_count == 0)
            $display("packet_delay_prefix_classifier_tb OK");
        else
            $display("packet_delay_prefix_classifier_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pdpc_pkg.sv
hw/rtl/pdpc_rule_table.sv
hw/rtl/packet_delay_prefix_classifier.sv
dv/packet_delay_prefix_classifier_tb.sv
